### hdl/cstn_pkg.sv
package cstn_pkg;

   // Geometry limits and field widths.
   localparam int MAX_GRID = 64;
   localparam int GRID_W   = 7;
   localparam int FACE_W   = 3;
   localparam int POS_W    = 6;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 8;
   localparam int WIDE_W   = 9;
   localparam int NSQ_W    = 13;
   localparam int IDX_W    = 15;
   localparam int NB_COUNT = 4;

   localparam logic [GRID_W-1:0] GRID_RESET = 7'd8;

   // Face codes.
   localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd0;
   localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd1;
   localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
   localparam logic [FACE_W-1:0] FACE_BACK   = 3'd3;
   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

   // Neighbour slots.
   localparam int NB_LEFT   = 0;
   localparam int NB_TOP    = 1;
   localparam int NB_RIGHT  = 2;
   localparam int NB_BOTTOM = 3;

   // Storage region of a neighbour.
   typedef enum logic [1:0] {
      REG_BAND,
      REG_TOP,
      REG_BOT
   } region_type;

   typedef struct packed {
      logic [FACE_W-1:0] face_id;
      logic [POS_W-1:0]  col_l;
      logic [POS_W-1:0]  row_m;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] left_index;
      logic [IDX_W-1:0] top_index;
      logic [IDX_W-1:0] right_index;
      logic [IDX_W-1:0] bottom_index;
      logic             in_range;
   } rsp_type;

   typedef struct packed {
      logic [GRID_W-1:0] grid_size;
   } cfg_type;

   typedef struct packed {
      region_type       region;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } nbr_type;

   // Output of the select stage.
   typedef struct packed {
      nbr_type [NB_COUNT-1:0] nbr;
      logic [GRID_W-1:0]      grid;
      logic [NSQ_W-1:0]       nsq;
      logic                   in_range;
   } sel_type;

   // Output of the scale stage.
   typedef struct packed {
      logic [NB_COUNT-1:0][IDX_W-1:0] base;
      logic [NB_COUNT-1:0][IDX_W-1:0] prod;
      logic [NB_COUNT-1:0][COL_W-1:0] col;
      logic                           in_range;
   } scale_type;

   function automatic nbr_type mk_nbr(region_type region, logic [ROW_W-1:0] row,
                                      logic [COL_W-1:0] col);
      nbr_type n;
      n.region = region;
      n.row    = row;
      n.col    = col;
      return n;
   endfunction

endpackage

### hdl/cstn_chan_if.sv
interface cstn_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/cstn_select.sv
module cstn_select (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cstn_pkg::req_type in_data,
   input  logic [cstn_pkg::GRID_W-1:0] grid,
   output logic              out_valid,
   input  logic              out_ready,
   output cstn_pkg::sel_type out_data
);

   logic                           valid_ff;
   cstn_pkg::sel_type              data_ff;
   cstn_pkg::sel_type              data_in;

   logic [cstn_pkg::FACE_W-1:0]    face;
   logic [cstn_pkg::POS_W-1:0]     l;
   logic [cstn_pkg::POS_W-1:0]     m;
   logic [cstn_pkg::ROW_W-1:0]     nm1;
   logic [cstn_pkg::ROW_W-1:0]     rowb;
   logic [cstn_pkg::ROW_W-1:0]     rowb_dec;
   logic [cstn_pkg::ROW_W-1:0]     rowb_inc;
   logic [cstn_pkg::ROW_W-1:0]     nl1;
   logic [cstn_pkg::ROW_W-1:0]     l_dec;
   logic [cstn_pkg::ROW_W-1:0]     l_inc;
   logic [cstn_pkg::WIDE_W-1:0]    n9;
   logic [cstn_pkg::WIDE_W-1:0]    w9;
   logic [cstn_pkg::WIDE_W-1:0]    colb9;
   logic [cstn_pkg::WIDE_W-1:0]    n_plus_l;
   logic [cstn_pkg::WIDE_W-1:0]    twon_plus_m;
   logic [cstn_pkg::WIDE_W-1:0]    fourn_m1_l;
   logic [cstn_pkg::WIDE_W-1:0]    threen_m1_m;
   logic [cstn_pkg::COL_W-1:0]     colb;
   logic [cstn_pkg::COL_W-1:0]     colb_left;
   logic [cstn_pkg::COL_W-1:0]     colb_right;
   logic [2*cstn_pkg::GRID_W-1:0]  nsq_full;
   logic                           grid_ok;

   // Position arithmetic shared by all neighbour cases.
   always_comb begin
      face        = in_data.face_id;
      l           = in_data.col_l;
      m           = in_data.row_m;
      nm1         = grid[cstn_pkg::ROW_W-1:0] - 6'd1;
      rowb        = nm1 - m;
      rowb_dec    = rowb - 6'd1;
      rowb_inc    = rowb + 6'd1;
      nl1         = nm1 - l;
      l_dec       = l - 6'd1;
      l_inc       = l + 6'd1;
      n9          = cstn_pkg::WIDE_W'(grid);
      w9          = n9 << 2;
      colb9       = cstn_pkg::WIDE_W'(face[1:0]) * n9 + cstn_pkg::WIDE_W'(l);
      n_plus_l    = n9 + cstn_pkg::WIDE_W'(l);
      twon_plus_m = (n9 << 1) + cstn_pkg::WIDE_W'(m);
      fourn_m1_l  = w9 - 9'd1 - cstn_pkg::WIDE_W'(l);
      threen_m1_m = (n9 << 1) + n9 - 9'd1 - cstn_pkg::WIDE_W'(m);
      colb        = colb9[cstn_pkg::COL_W-1:0];
      colb_left   = (colb9 == '0) ? 8'(w9 - 9'd1) : 8'(colb9 - 9'd1);
      colb_right  = (colb9 == w9 - 9'd1) ? '0 : 8'(colb9 + 9'd1);
      nsq_full    = (2*cstn_pkg::GRID_W)'(grid) * (2*cstn_pkg::GRID_W)'(grid);
      grid_ok     = (grid != '0) && (int'(grid) <= cstn_pkg::MAX_GRID);
   end

   // Neighbour selection: region, row and column of each of the four neighbours.
   always_comb begin
      data_in          = '0;
      data_in.grid     = grid;
      data_in.nsq      = nsq_full[cstn_pkg::NSQ_W-1:0];
      data_in.in_range = grid_ok && (face <= cstn_pkg::FACE_BOTTOM) &&
                         (cstn_pkg::GRID_W'(l) < grid) && (cstn_pkg::GRID_W'(m) < grid);
      case (face) inside
         [cstn_pkg::FACE_LEFT:cstn_pkg::FACE_BACK]: begin
            data_in.nbr[cstn_pkg::NB_LEFT]  = cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, rowb,
                                                               colb_left);
            data_in.nbr[cstn_pkg::NB_RIGHT] = cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, rowb,
                                                               colb_right);
            if (m != nm1) begin
               data_in.nbr[cstn_pkg::NB_TOP] = cstn_pkg::mk_nbr(cstn_pkg::REG_BAND,
                                                                rowb_dec, colb);
            end else begin
               case (face)
                  cstn_pkg::FACE_LEFT:
                     data_in.nbr[cstn_pkg::NB_TOP] = cstn_pkg::mk_nbr(cstn_pkg::REG_TOP,
                                                                      l, '0);
                  cstn_pkg::FACE_FRONT:
                     data_in.nbr[cstn_pkg::NB_TOP] = cstn_pkg::mk_nbr(cstn_pkg::REG_TOP,
                                                                      nm1, 8'(l));
                  cstn_pkg::FACE_RIGHT:
                     data_in.nbr[cstn_pkg::NB_TOP] = cstn_pkg::mk_nbr(cstn_pkg::REG_TOP,
                                                                      nl1, 8'(nm1));
                  default:
                     data_in.nbr[cstn_pkg::NB_TOP] = cstn_pkg::mk_nbr(cstn_pkg::REG_TOP,
                                                                      '0, 8'(nl1));
               endcase
            end
            if (m != '0) begin
               data_in.nbr[cstn_pkg::NB_BOTTOM] = cstn_pkg::mk_nbr(cstn_pkg::REG_BAND,
                                                                   rowb_inc, colb);
            end else begin
               case (face)
                  cstn_pkg::FACE_LEFT:
                     data_in.nbr[cstn_pkg::NB_BOTTOM] = cstn_pkg::mk_nbr(cstn_pkg::REG_BOT,
                                                                         nl1, '0);
                  cstn_pkg::FACE_FRONT:
                     data_in.nbr[cstn_pkg::NB_BOTTOM] = cstn_pkg::mk_nbr(cstn_pkg::REG_BOT,
                                                                         '0, 8'(l));
                  cstn_pkg::FACE_RIGHT:
                     data_in.nbr[cstn_pkg::NB_BOTTOM] = cstn_pkg::mk_nbr(cstn_pkg::REG_BOT,
                                                                         l, 8'(nm1));
                  default:
                     data_in.nbr[cstn_pkg::NB_BOTTOM] = cstn_pkg::mk_nbr(cstn_pkg::REG_BOT,
                                                                         nm1, 8'(nl1));
               endcase
            end
         end
         cstn_pkg::FACE_TOP: begin
            data_in.nbr[cstn_pkg::NB_LEFT] = (l == '0) ?
               cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, '0, 8'(rowb)) :
               cstn_pkg::mk_nbr(cstn_pkg::REG_TOP, rowb, 8'(l_dec));
            data_in.nbr[cstn_pkg::NB_RIGHT] = (l == nm1) ?
               cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, '0, 8'(twon_plus_m)) :
               cstn_pkg::mk_nbr(cstn_pkg::REG_TOP, rowb, 8'(l_inc));
            data_in.nbr[cstn_pkg::NB_BOTTOM] = (m == '0) ?
               cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, '0, 8'(n_plus_l)) :
               cstn_pkg::mk_nbr(cstn_pkg::REG_TOP, rowb_inc, 8'(l));
            data_in.nbr[cstn_pkg::NB_TOP] = (m == nm1) ?
               cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, '0, 8'(fourn_m1_l)) :
               cstn_pkg::mk_nbr(cstn_pkg::REG_TOP, rowb_dec, 8'(l));
         end
         cstn_pkg::FACE_BOTTOM: begin
            data_in.nbr[cstn_pkg::NB_LEFT] = (l == '0) ?
               cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, nm1, 8'(m)) :
               cstn_pkg::mk_nbr(cstn_pkg::REG_BOT, rowb, 8'(l_dec));
            data_in.nbr[cstn_pkg::NB_RIGHT] = (l == nm1) ?
               cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, nm1, 8'(threen_m1_m)) :
               cstn_pkg::mk_nbr(cstn_pkg::REG_BOT, rowb, 8'(l_inc));
            data_in.nbr[cstn_pkg::NB_BOTTOM] = (m == '0) ?
               cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, nm1, 8'(fourn_m1_l)) :
               cstn_pkg::mk_nbr(cstn_pkg::REG_BOT, rowb_inc, 8'(l));
            data_in.nbr[cstn_pkg::NB_TOP] = (m == nm1) ?
               cstn_pkg::mk_nbr(cstn_pkg::REG_BAND, nm1, 8'(n_plus_l)) :
               cstn_pkg::mk_nbr(cstn_pkg::REG_BOT, rowb_dec, 8'(l));
         end
         default: begin
            data_in.in_range = 1'b0;
         end
      endcase
   end

   // Stage register; it loads whenever it is empty or its beat moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hdl/cstn_scale.sv
module cstn_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cstn_pkg::sel_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output cstn_pkg::scale_type out_data
);

   logic                          valid_ff;
   cstn_pkg::scale_type           data_ff;
   cstn_pkg::scale_type           data_in;
   logic [cstn_pkg::WIDE_W-1:0]   n9;
   logic [cstn_pkg::WIDE_W-1:0]   w9;
   logic [cstn_pkg::IDX_W-1:0]    nsq4;
   logic [cstn_pkg::IDX_W-1:0]    nsq5;
   logic [cstn_pkg::WIDE_W-1:0]   stride [cstn_pkg::NB_COUNT];

   // Row times row pitch, and the base of the storage region, per neighbour.
   always_comb begin
      n9               = cstn_pkg::WIDE_W'(in_data.grid);
      w9               = n9 << 2;
      nsq4             = cstn_pkg::IDX_W'(in_data.nsq) << 2;
      nsq5             = nsq4 + cstn_pkg::IDX_W'(in_data.nsq);
      data_in          = '0;
      data_in.in_range = in_data.in_range;
      for (int k = 0; k < cstn_pkg::NB_COUNT; k++) begin
         stride[k] = (in_data.nbr[k].region == cstn_pkg::REG_BAND) ? w9 : n9;
         data_in.prod[k] = cstn_pkg::IDX_W'(in_data.nbr[k].row) *
                           cstn_pkg::IDX_W'(stride[k]);
         data_in.col[k]  = in_data.nbr[k].col;
         unique case (in_data.nbr[k].region)
            cstn_pkg::REG_BAND: data_in.base[k] = '0;
            cstn_pkg::REG_TOP:  data_in.base[k] = nsq4;
            cstn_pkg::REG_BOT:  data_in.base[k] = nsq5;
            default:            data_in.base[k] = '0;
         endcase
      end
   end

   // Stage register.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hdl/cstn_sum.sv
module cstn_sum (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cstn_pkg::scale_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output cstn_pkg::rsp_type   out_data
);

   logic                        valid_ff;
   cstn_pkg::rsp_type           data_ff;
   cstn_pkg::rsp_type           data_in;
   logic [cstn_pkg::IDX_W-1:0]  idx [cstn_pkg::NB_COUNT];

   // Final index: region base plus row offset plus column; zero when out of range.
   always_comb begin
      for (int k = 0; k < cstn_pkg::NB_COUNT; k++) begin
         idx[k] = in_data.in_range ?
                  in_data.base[k] + in_data.prod[k] + cstn_pkg::IDX_W'(in_data.col[k]) : '0;
      end
      data_in.left_index   = idx[cstn_pkg::NB_LEFT];
      data_in.top_index    = idx[cstn_pkg::NB_TOP];
      data_in.right_index  = idx[cstn_pkg::NB_RIGHT];
      data_in.bottom_index = idx[cstn_pkg::NB_BOTTOM];
      data_in.in_range     = in_data.in_range;
   end

   // Output register; holds the beat until the consumer takes it.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hdl/cube_surface_tile_neighbours.sv
// Cube surface tile neighbour indexer. Each request beat names a tile by face, column
// and row; the response beat gives the storage indices of its left, top, right and
// bottom neighbours (side band of 4N columns, then top cap, then bottom cap) and an
// in_range flag, with all indices zero when the tile, face or grid size is invalid.
// The block takes one beat per cycle unless the response side stalls, and answers in
// order; each request passes the three register stages (neighbour select, row-pitch
// multiply, final add) before its response appears.
// Write grid_size on the csr channel only while no beats are in flight.
module cube_surface_tile_neighbours (
   input  logic        clock,
   input  logic        reset,
   cstn_chan_if.sink   req_bus,
   cstn_chan_if.source rsp_bus,
   cstn_chan_if.sink   csr_bus
);

   logic [cstn_pkg::GRID_W-1:0] grid_ff;
   logic                        sel_valid;
   logic                        sel_ready;
   cstn_pkg::sel_type           sel_data;
   logic                        scl_valid;
   logic                        scl_ready;
   cstn_pkg::scale_type         scl_data;
   cstn_pkg::req_type           req_data;
   cstn_pkg::cfg_type           csr_data;
   cstn_pkg::rsp_type           rsp_data;

   // Grid size register; writes are always taken.
   assign csr_bus.ready = 1'b1;
   assign csr_data      = csr_bus.payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= cstn_pkg::GRID_RESET;
      end else if (csr_bus.valid) begin
         grid_ff <= csr_data.grid_size;
      end
   end

   assign req_data        = req_bus.payload;
   assign rsp_bus.payload = rsp_data;

   cstn_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_data),
      .grid      (grid_ff),
      .out_valid (sel_valid),
      .out_ready (sel_ready),
      .out_data  (sel_data)
   );

   cstn_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_data   (sel_data),
      .out_valid (scl_valid),
      .out_ready (scl_ready),
      .out_data  (scl_data)
   );

   cstn_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scl_valid),
      .in_ready  (scl_ready),
      .in_data   (scl_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

endmodule

### hdl/cstn_checker.sv
module cstn_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cstn_pkg::rsp_type rsp_payload
);

   // A stalled response beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // An out-of-range tile carries all-zero indices.
   a_zero_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.in_range |->
         (rsp_payload.left_index == '0) && (rsp_payload.top_index == '0) &&
         (rsp_payload.right_index == '0) && (rsp_payload.bottom_index == '0))
      else $error("out-of-range response with nonzero index");

   // With the response side open, a taken request is answered with a response beat.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after pipeline latency");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

endmodule

bind cube_surface_tile_neighbours cstn_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);
